### rtl/agq_pkg.sv
// Shared types, constants and lookup functions for the adaptive gray-to-ASCII quantizer.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package agq_pkg;

   // Frame store geometry
   localparam int MAX_COLUMNS = 128;
   localparam int MAX_ROWS    = 64;
   localparam int DEPTH       = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int PIX_W       = 8;
   localparam int SUM_W       = PIX_W + ADDR_W;
   localparam int COL_W       = $clog2(MAX_COLUMNS);
   localparam int WID_W       = 8;
   localparam int CHAR_W      = 7;

   localparam logic [WID_W-1:0] ROW_WIDTH_RESET = WID_W'(80);

   // Threshold sequencer
   localparam int NUM_THR = 11;
   localparam int TIDX_W  = $clog2(NUM_THR);
   localparam int CLS_W   = $clog2(NUM_THR + 1);
   localparam int NUM_W   = 11;
   localparam int MEAN_IDX = 5;
   // floor(n/3) == (n * 0xAAAB) >> 17 for every n below 2**16
   localparam logic [15:0] RECIP3 = 16'hAAAB;
   localparam int RECIP3_SH = 17;

   typedef enum logic [1:0] {
      DV_ONE   = 2'd0,
      DV_TWO   = 2'd1,
      DV_THREE = 2'd2,
      DV_SIX   = 2'd3
   } div_kind_type;

   typedef struct packed {
      logic [2:0]   ka;      // weight of the mean
      logic [2:0]   kb;      // weight of the minimum or maximum
      logic         use_max; // second operand is the maximum, else the minimum
      div_kind_type dv;
   } coef_type;

   // Frame store access
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] waddr;
      logic [PIX_W-1:0]  wdata;
      logic              rd_en;
      logic [ADDR_W-1:0] raddr;
   } store_req_type;

   // Mean divider launch
   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] dividend;
      logic [CNT_W-1:0] divisor;
   } div_req_type;

   // Threshold sequencer launch
   typedef struct packed {
      logic             start;
      logic [PIX_W-1:0] mean;
      logic [PIX_W-1:0] min;
      logic [PIX_W-1:0] max;
   } thr_req_type;

   // Blend weights and divisor for each threshold, darkest first
   function automatic coef_type thr_coef(input logic [TIDX_W-1:0] idx);
      coef_type c;
      c = '{ka: 3'd1, kb: 3'd0, use_max: 1'b0, dv: DV_ONE};
      unique case (idx)
         4'd0:    c = '{ka: 3'd1, kb: 3'd5, use_max: 1'b0, dv: DV_SIX};
         4'd1:    c = '{ka: 3'd1, kb: 3'd2, use_max: 1'b0, dv: DV_THREE};
         4'd2:    c = '{ka: 3'd1, kb: 3'd1, use_max: 1'b0, dv: DV_TWO};
         4'd3:    c = '{ka: 3'd2, kb: 3'd1, use_max: 1'b0, dv: DV_THREE};
         4'd4:    c = '{ka: 3'd5, kb: 3'd1, use_max: 1'b0, dv: DV_SIX};
         4'd5:    c = '{ka: 3'd1, kb: 3'd0, use_max: 1'b0, dv: DV_ONE};
         4'd6:    c = '{ka: 3'd5, kb: 3'd1, use_max: 1'b1, dv: DV_SIX};
         4'd7:    c = '{ka: 3'd2, kb: 3'd1, use_max: 1'b1, dv: DV_THREE};
         4'd8:    c = '{ka: 3'd1, kb: 3'd1, use_max: 1'b1, dv: DV_TWO};
         4'd9:    c = '{ka: 3'd1, kb: 3'd2, use_max: 1'b1, dv: DV_THREE};
         4'd10:   c = '{ka: 3'd1, kb: 3'd5, use_max: 1'b1, dv: DV_SIX};
         default: c = '{ka: 3'd1, kb: 3'd0, use_max: 1'b0, dv: DV_ONE};
      endcase
      return c;
   endfunction

   // Character for each brightness class, darkest first
   function automatic logic [CHAR_W-1:0] glyph_of(input logic [CLS_W-1:0] cls);
      logic [CHAR_W-1:0] g;
      g = CHAR_W'(8'h20);
      unique case (cls)
         4'd0:    g = CHAR_W'(8'h20); // space
         4'd1:    g = CHAR_W'(8'h60); // backtick
         4'd2:    g = CHAR_W'(8'h2D); // -
         4'd3:    g = CHAR_W'(8'h3A); // :
         4'd4:    g = CHAR_W'(8'h3B); // ;
         4'd5:    g = CHAR_W'(8'h72); // r
         4'd6:    g = CHAR_W'(8'h69); // i
         4'd7:    g = CHAR_W'(8'h49); // I
         4'd8:    g = CHAR_W'(8'h4B); // K
         4'd9:    g = CHAR_W'(8'h47); // G
         4'd10:   g = CHAR_W'(8'h40); // @
         4'd11:   g = CHAR_W'(8'h42); // B
         default: g = CHAR_W'(8'h20);
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

### rtl/agq_store.sv
// Frame pixel store: one write port, one read port, registered read data.
// Depends on agq_pkg for depth, widths and the access struct.
`timescale 1ns / 1ps
`default_nettype none

module agq_store (
   input  wire                           clock,
   input  agq_pkg::store_req_type        store_req,
   output logic [agq_pkg::PIX_W-1:0]     rdata
);
   import agq_pkg::*;

   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rdata_ff;

   // Write a loaded pixel, read the next one to classify
   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.waddr] <= store_req.wdata;
      end
      if (store_req.rd_en) begin
         rdata_ff <= mem[store_req.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### rtl/agq_div.sv
// Restoring divider for the frame mean: one quotient bit per cycle.
// Depends on agq_pkg for the sum and count widths.
`timescale 1ns / 1ps
`default_nettype none

module agq_div (
   input  wire                          clock,
   input  wire                          reset,
   input  agq_pkg::div_req_type         div_req,
   output logic                         done,
   output logic [agq_pkg::PIX_W-1:0]    quotient
);
   import agq_pkg::*;

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  dsr_ff, dsr_in;
   logic [CNT_W:0]    trial;
   logic              fits;

   // Shift in the next dividend bit and try the subtraction
   always_comb begin
      trial = {rem_ff, quo_ff[SUM_W-1]};
      fits  = trial >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? CNT_W'(trial - {1'b0, dsr_ff}) : CNT_W'(trial);
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsr_ff  <= dsr_in;
   end

   // The mean of 8-bit pixels always fits in a pixel
   assign done     = done_ff;
   assign quotient = quo_ff[PIX_W-1:0];

endmodule

`default_nettype wire

### rtl/agq_thresh.sv
// Threshold sequencer and pixel classifier: eleven blended thresholds,
// one per cycle through a two-stage multiply path. Depends on agq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module agq_thresh (
   input  wire                          clock,
   input  wire                          reset,
   input  agq_pkg::thr_req_type         thr_req,
   input  wire [agq_pkg::PIX_W-1:0]     pixel,
   output logic                         done,
   output logic [agq_pkg::CHAR_W-1:0]   glyph
);
   import agq_pkg::*;

   localparam int PROD_W = NUM_W + 16;

   logic              run_ff, run_in;
   logic [TIDX_W-1:0] idx_ff, idx_in;
   logic [PIX_W-1:0]  mean_ff, mean_in;
   logic [PIX_W-1:0]  min_ff, min_in;
   logic [PIX_W-1:0]  max_ff, max_in;
   logic              v_ff;
   logic [NUM_W-1:0]  num_ff, num_in;
   div_kind_type      dv_ff;
   logic [TIDX_W-1:0] widx_ff;
   logic [PIX_W-1:0]  thr_ff [NUM_THR];

   coef_type          coef;
   logic [PIX_W-1:0]  opnd_b;
   logic [PROD_W-1:0] prod;
   logic [9:0]        q3;
   logic [PIX_W-1:0]  thr_val;
   logic [CLS_W-1:0]  cls;

   // Stage one: step through the thresholds and form the blended numerator
   always_comb begin
      coef    = thr_coef(idx_ff);
      opnd_b  = coef.use_max ? max_ff : min_ff;
      num_in  = NUM_W'(coef.ka) * NUM_W'(mean_ff) + NUM_W'(coef.kb) * NUM_W'(opnd_b);
      run_in  = run_ff;
      idx_in  = idx_ff;
      mean_in = mean_ff;
      min_in  = min_ff;
      max_in  = max_ff;
      if (thr_req.start) begin
         run_in  = 1'b1;
         idx_in  = '0;
         mean_in = thr_req.mean;
         min_in  = thr_req.min;
         max_in  = thr_req.max;
      end else if (run_ff) begin
         idx_in = idx_ff + 1'b1;
         if (idx_ff == TIDX_W'(NUM_THR - 1)) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         v_ff   <= 1'b0;
      end else begin
         run_ff <= run_in;
         v_ff   <= run_ff;
      end
      idx_ff  <= idx_in;
      mean_ff <= mean_in;
      min_ff  <= min_in;
      max_ff  <= max_in;
      num_ff  <= num_in;
      dv_ff   <= coef.dv;
      widx_ff <= idx_ff;
   end

   // Stage two: divide by one, two, three or six; halves by a shift, thirds through a reciprocal multiply
   always_comb begin
      prod = PROD_W'(num_ff) * PROD_W'(RECIP3);
      q3   = prod[RECIP3_SH +: 10];
      unique case (dv_ff)
         DV_ONE:   thr_val = num_ff[PIX_W-1:0];
         DV_TWO:   thr_val = num_ff[PIX_W:1];
         DV_THREE: thr_val = q3[PIX_W-1:0];
         DV_SIX:   thr_val = q3[PIX_W:1];
         default:  thr_val = num_ff[PIX_W-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (v_ff) begin
         thr_ff[widx_ff] <= thr_val;
      end
   end

   assign done = v_ff && (widx_ff == TIDX_W'(NUM_THR - 1));

   // Classify: below the mean search downward, else upward
   always_comb begin
      if (pixel < thr_ff[MEAN_IDX]) begin
         priority if (pixel > thr_ff[4]) cls = CLS_W'(5);
         else if (pixel > thr_ff[3])     cls = CLS_W'(4);
         else if (pixel > thr_ff[2])     cls = CLS_W'(3);
         else if (pixel > thr_ff[1])     cls = CLS_W'(2);
         else if (pixel > thr_ff[0])     cls = CLS_W'(1);
         else                            cls = CLS_W'(0);
      end else begin
         priority if (pixel < thr_ff[6]) cls = CLS_W'(6);
         else if (pixel < thr_ff[7])     cls = CLS_W'(7);
         else if (pixel < thr_ff[8])     cls = CLS_W'(8);
         else if (pixel < thr_ff[9])     cls = CLS_W'(9);
         else if (pixel < thr_ff[10])    cls = CLS_W'(10);
         else                            cls = CLS_W'(11);
      end
   end

   assign glyph = glyph_of(cls);

endmodule

`default_nettype wire

### rtl/adaptive_gray_to_ascii_quantizer.sv
// Top level of the adaptive gray-to-ASCII quantizer: request control, frame statistics,
// output register. Depends on agq_pkg, agq_store, agq_div and agq_thresh.
//
//   channel  ports                      payload
//   req      req_tvalid / req_tready    tuser: func, tdata[7:0]: pixel, tlast: last
//   rsp      rsp_tvalid / rsp_tready    tdata[6:0]: char_code, tuser: row_end, tlast: frame_end
//   csr      csr_wr_en                  csr_wr_data[7:0]: row_width
//
// A character request takes two steps (store read, then classify); no request is taken until its
// result is registered. The request marked last starts the mean divider (21 quotient bits), then
// the threshold sequencer; no request is taken until the sequencer is done.
// Reset is synchronous; the pixel store is not cleared, only entries of the current frame are read.
// A stalled result holds in the output register; one further request may be taken behind it.
`timescale 1ns / 1ps
`default_nettype none

module adaptive_gray_to_ascii_quantizer (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [7:0]                        req_tdata,   // [7:0] pixel
   input  wire                               req_tuser,   // [0] func
   input  wire                               req_tlast,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [7:0]                        rsp_tdata,   // [6:0] char_code, [7] zero
   output logic                              rsp_tuser,   // [0] row_end
   output logic                              rsp_tlast,
   input  wire                               csr_wr_en,
   input  wire  [agq_pkg::WID_W-1:0]         csr_wr_data
);
   import agq_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_THR  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [PIX_W-1:0]  min_ff, min_in;
   logic [PIX_W-1:0]  max_ff, max_in;
   logic [CNT_W-1:0]  rdpos_ff, rdpos_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              ready_ff, ready_in;
   logic [WID_W-1:0]  width_ff;
   logic              rspv_ff, rspv_in;
   logic [CHAR_W-1:0] rchar_ff, rchar_in;
   logic              rrow_ff, rrow_in;
   logic              rfrm_ff, rfrm_in;

   store_req_type     store_req;
   div_req_type       div_req;
   thr_req_type       thr_req;
   logic [PIX_W-1:0]  rd_pixel;
   logic              div_done;
   logic [PIX_W-1:0]  mean;
   logic              thr_done;
   logic [CHAR_W-1:0] glyph;

   logic              req_acc, load_acc, read_acc, hit;
   logic [CNT_W-1:0]  base_cnt, new_cnt;
   logic [SUM_W-1:0]  base_sum, new_sum;
   logic [PIX_W-1:0]  base_min, new_min, base_max, new_max;
   logic              room, emit_go, fend, rend;
   logic [WID_W-1:0]  eff_width, col_next;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign load_acc   = req_acc && !req_tuser;
   assign read_acc   = req_acc && req_tuser;
   assign hit        = ready_ff && (rdpos_ff < cnt_ff);

   // Fold a loaded pixel into the statistics, opening a new frame if needed
   always_comb begin
      base_cnt = ready_ff ? '0 : cnt_ff;
      base_sum = ready_ff ? '0 : sum_ff;
      base_min = ready_ff ? '1 : min_ff;
      base_max = ready_ff ? '0 : max_ff;
      room     = base_cnt < CNT_W'(DEPTH);
      new_cnt  = room ? CNT_W'(base_cnt + 1'b1) : base_cnt;
      new_sum  = room ? SUM_W'(base_sum + SUM_W'(req_tdata)) : base_sum;
      new_min  = (room && req_tdata < base_min) ? req_tdata : base_min;
      new_max  = (room && req_tdata > base_max) ? req_tdata : base_max;
   end

   // Row-end and frame-end marks for the character on its way out
   always_comb begin
      priority if (width_ff == '0)               eff_width = WID_W'(1);
      else if (width_ff > WID_W'(MAX_COLUMNS))   eff_width = WID_W'(MAX_COLUMNS);
      else                                       eff_width = width_ff;
      col_next = WID_W'(col_ff) + 1'b1;
      fend     = (CNT_W'(rdpos_ff + 1'b1) == cnt_ff);
      rend     = (col_next >= eff_width) || fend;
      emit_go  = (state_ff == ST_EMIT) && (!rspv_ff || rsp_tready);
   end

   // Drive the store, launch the divider and the threshold sequencer
   always_comb begin
      store_req.wr_en = load_acc && room;
      store_req.waddr = base_cnt[ADDR_W-1:0];
      store_req.wdata = req_tdata;
      store_req.rd_en = read_acc && hit;
      store_req.raddr = rdpos_ff[ADDR_W-1:0];

      div_req.start    = load_acc && req_tlast && (new_cnt != '0);
      div_req.dividend = new_sum;
      div_req.divisor  = new_cnt;

      thr_req.start = (load_acc && req_tlast && (new_cnt == '0))
                      || ((state_ff == ST_DIV) && div_done);
      thr_req.mean  = (state_ff == ST_DIV) ? mean : '0;
      thr_req.min   = (state_ff == ST_DIV) ? min_ff : '0;
      thr_req.max   = (state_ff == ST_DIV) ? max_ff : '0;
   end

   // Sequence requests, frame close and result hand-off
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      rdpos_in = rdpos_ff;
      col_in   = col_ff;
      ready_in = ready_ff;
      rspv_in  = rspv_ff && !rsp_tready;
      rchar_in = rchar_ff;
      rrow_in  = rrow_ff;
      rfrm_in  = rfrm_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (load_acc) begin
               cnt_in   = new_cnt;
               sum_in   = new_sum;
               min_in   = new_min;
               max_in   = new_max;
               rdpos_in = '0;
               col_in   = '0;
               ready_in = 1'b0;
               if (req_tlast) begin
                  state_in = (new_cnt == '0) ? ST_THR : ST_DIV;
               end
            end else if (read_acc && hit) begin
               state_in = ST_EMIT;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_THR;
            end
         end
         ST_THR: begin
            if (thr_done) begin
               ready_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               rspv_in  = 1'b1;
               rchar_in = glyph;
               rrow_in  = rend;
               rfrm_in  = fend;
               rdpos_in = CNT_W'(rdpos_ff + 1'b1);
               col_in   = rend ? '0 : col_next[COL_W-1:0];
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         sum_ff   <= '0;
         min_ff   <= '1;
         max_ff   <= '0;
         rdpos_ff <= '0;
         col_ff   <= '0;
         ready_ff <= 1'b0;
         rspv_ff  <= 1'b0;
         width_ff <= ROW_WIDTH_RESET;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         rdpos_ff <= rdpos_in;
         col_ff   <= col_in;
         ready_ff <= ready_in;
         rspv_ff  <= rspv_in;
         if (csr_wr_en) begin
            width_ff <= csr_wr_data;
         end
      end
      rchar_ff <= rchar_in;
      rrow_ff  <= rrow_in;
      rfrm_ff  <= rfrm_in;
   end

   assign rsp_tvalid = rspv_ff;
   assign rsp_tdata  = {1'b0, rchar_ff};
   assign rsp_tuser  = rrow_ff;
   assign rsp_tlast  = rfrm_ff;

   agq_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .rdata     (rd_pixel)
   );

   agq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .done     (div_done),
      .quotient (mean)
   );

   agq_thresh u_thresh (
      .clock   (clock),
      .reset   (reset),
      .thr_req (thr_req),
      .pixel   (rd_pixel),
      .done    (thr_done),
      .glyph   (glyph)
   );

`ifndef SYNTHESIS
   a_rdpos_bound: assert property (@(posedge clock) disable iff (reset)
      rdpos_ff <= cnt_ff)
      else $error("read position past loaded count");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("loaded count past store depth");

   a_emit_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> ready_ff && rdpos_ff < cnt_ff)
      else $error("character fetched outside a finished frame");

   a_frame_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("frame end without row end");

   a_div_then_thr: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV && div_done |=> state_ff == ST_THR)
      else $error("threshold pass not started after mean");
`endif

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for adaptive_gray_to_ascii_quantizer: a directed table, then random
// frames, read requests and noise, checked against a predictor of the block or typed characters.
// Depends on agq_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
   import agq_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 12;
   localparam int SETTLE_CYCLES = 50;   // frame close: divider plus threshold sequencer
   localparam int STALL_LIMIT   = 2000; // cycles without any handshake
   localparam int PHASE_ITEMS   = 90;

   localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
   localparam logic [CHAR_W-1:0] CH_BLOCK = 7'h42;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      CHK_MODEL = 2'd0, // predictor decides
      CHK_NONE  = 2'd1, // no character may come
      CHK_GIVEN = 2'd2  // character typed into the row
   } check_type;

   typedef struct packed {
      logic [CHAR_W-1:0] glyph;
      logic              row_end;
      logic              frame_end;
   } char_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] pixel;
      logic       mark;
      check_type  kind;
      char_type   given;
   } dir_row_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic [7:0]        req_tdata   = '0;
   logic              req_tuser   = 1'b0;
   logic              req_tlast   = 1'b0;
   logic              rsp_tready  = 1'b0;
   logic              csr_wr_en   = 1'b0;
   logic [WID_W-1:0]  csr_wr_data = '0;
   logic              req_tready;
   logic              rsp_tvalid;
   logic [7:0]        rsp_tdata;
   logic              rsp_tuser;
   logic              rsp_tlast;

   int unsigned       send_idle_pct;
   int unsigned       recv_idle_pct;
   int unsigned       fails;
   int unsigned       quiet_cycles;
   char_type          pending_chars[$];
   dir_row_type       directed_rows[25];

   // Predictor state
   logic [7:0]        gray_store[DEPTH];
   int unsigned       gray_sum;
   int unsigned       gray_min;
   int unsigned       gray_max;
   int unsigned       gray_count;
   int unsigned       emit_pos;
   int unsigned       col_pos;
   int unsigned       level_bound[11];
   bit                frame_done;
   int unsigned       text_width;

   adaptive_gray_to_ascii_quantizer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Character set, darkest first
   function automatic logic [CHAR_W-1:0] glyph_code(input int unsigned level);
      case (level)
         0:       return 7'h20; // space
         1:       return 7'h60; // backtick
         2:       return 7'h2D; // -
         3:       return 7'h3A; // :
         4:       return 7'h3B; // ;
         5:       return 7'h72; // r
         6:       return 7'h69; // i
         7:       return 7'h49; // I
         8:       return 7'h4B; // K
         9:       return 7'h47; // G
         10:      return 7'h40; // @
         default: return 7'h42; // B
      endcase
   endfunction

   function automatic void clear_stats();
      gray_sum   = 0;
      gray_min   = 255;
      gray_max   = 0;
      gray_count = 0;
      emit_pos   = 0;
      col_pos    = 0;
      frame_done = 1'b0;
   endfunction

   // Blend floor mean with minimum and maximum into the eleven bounds
   function automatic void finish_frame();
      int unsigned a;
      int unsigned m;
      int unsigned x;
      a = (gray_count != 0) ? gray_sum / gray_count : 0;
      m = (gray_count != 0) ? gray_min : 0;
      x = (gray_count != 0) ? gray_max : 0;
      level_bound[0]  = (a + 5 * m) / 6;
      level_bound[1]  = (a + 2 * m) / 3;
      level_bound[2]  = (a + m) / 2;
      level_bound[3]  = (2 * a + m) / 3;
      level_bound[4]  = (5 * a + m) / 6;
      level_bound[5]  = a;
      level_bound[6]  = (x + 5 * a) / 6;
      level_bound[7]  = (x + 2 * a) / 3;
      level_bound[8]  = (x + a) / 2;
      level_bound[9]  = (2 * x + a) / 3;
      level_bound[10] = (5 * x + a) / 6;
      frame_done = 1'b1;
   endfunction

   function automatic int unsigned brightness_level(input int unsigned p);
      if (p < level_bound[5]) begin
         for (int i = 4; i >= 0; i--) begin
            if (p > level_bound[i]) return i + 1;
         end
         return 0;
      end
      for (int i = 6; i <= 10; i++) begin
         if (p < level_bound[i]) return i;
      end
      return 11;
   endfunction

   // Advance the predictor by one request; return 1 when a character is due
   function automatic bit quantize_request(input op_type op, input logic [7:0] pix,
                                           input logic mark, output char_type res);
      int unsigned w;
      bit          last_char;
      bit          row_done;
      res = '0;
      if (op == OP_LOAD) begin
         if (frame_done) clear_stats();
         if (gray_count < DEPTH) begin
            gray_store[gray_count] = pix;
            gray_count++;
            gray_sum += pix;
            if (pix < gray_min) gray_min = pix;
            if (pix > gray_max) gray_max = pix;
         end
         if (mark) finish_frame();
         return 1'b0;
      end
      if (!frame_done || emit_pos >= gray_count) return 1'b0;
      w = (text_width == 0) ? 1 : (text_width > MAX_COLUMNS) ? MAX_COLUMNS : text_width;
      last_char     = (emit_pos + 1 == gray_count);
      row_done      = (col_pos + 1 >= w) || last_char;
      col_pos       = row_done ? 0 : col_pos + 1;
      res.glyph     = glyph_code(brightness_level(gray_store[emit_pos]));
      res.row_end   = row_done;
      res.frame_end = last_char;
      emit_pos++;
      return 1'b1;
   endfunction

   function automatic dir_row_type mk_row(input op_type op, input logic [7:0] pix,
                                          input logic mark, input check_type kind,
                                          input char_type given);
      dir_row_type r;
      r.op    = op;
      r.pixel = pix;
      r.mark  = mark;
      r.kind  = kind;
      r.given = given;
      return r;
   endfunction

   task automatic compare_field(input string what, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         fails++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      end
   endtask

   // Present one request, hold it until taken, then record what it should produce
   task automatic issue_request(input op_type op, input logic [7:0] pix, input logic mark,
                                input check_type kind, input char_type given,
                                output bit produced);
      char_type res;
      bit       has;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= pix;
      req_tlast  <= mark;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      has = quantize_request(op, pix, mark, res);
      if (kind == CHK_GIVEN) pending_chars.push_back(given);
      else if (kind == CHK_MODEL && has) pending_chars.push_back(res);
      produced = has;
   endtask

   task automatic await_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_chars.size() != 0);
   endtask

   // Write the row width only once the block has gone quiet
   task automatic write_row_width(input logic [WID_W-1:0] w);
      await_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= w;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      text_width  = w;
   endtask

   // Random frames with random content, partial and surplus reads, and noise
   task automatic run_phase(input int unsigned budget);
      int unsigned counted;
      int unsigned n;
      int unsigned k;
      int unsigned lo;
      int unsigned hi;
      int unsigned style;
      int unsigned r;
      logic [7:0]  pix;
      op_type      op;
      bit          got;
      counted = 0;
      // reads first: a column count beyond a narrower width must end the row
      repeat (2) begin
         issue_request(OP_READ, 8'($urandom), 1'($urandom), CHK_MODEL, '0, got);
         if (got) counted++;
      end
      while (counted < budget) begin
         r = $urandom_range(99);
         if (r < 4) await_drain();
         if (r < 85) begin
            n     = ($urandom_range(9) == 0) ? $urandom_range(140, 25) : $urandom_range(24, 1);
            style = $urandom_range(3);
            lo    = $urandom_range(255);
            hi    = (style == 1) ? ((lo + $urandom_range(8) > 255) ? 255 : lo + $urandom_range(8))
                                 : $urandom_range(255, lo);
            if (style == 0) begin
               lo = 0;
               hi = 255;
            end
            for (int i = 0; i < n; i++) begin
               if (i > 0 && $urandom_range(19) == 0) begin
                  issue_request(OP_READ, 8'($urandom), 1'($urandom), CHK_MODEL, '0, got);
                  if (got) counted++;
               end
               pix = (style == 2) ? ($urandom_range(1) ? 8'(hi) : 8'(lo))
                                  : 8'($urandom_range(hi, lo));
               issue_request(OP_LOAD, pix, (i == n - 1), CHK_MODEL, '0, got);
               counted++;
            end
            k = ($urandom_range(4) == 0) ? $urandom_range(n, 0) : n + $urandom_range(2);
            repeat (k) begin
               issue_request(OP_READ, 8'($urandom), 1'($urandom), CHK_MODEL, '0, got);
               if (got) counted++;
            end
         end else begin
            repeat ($urandom_range(6, 1)) begin
               op = op_type'($urandom_range(1));
               issue_request(op, 8'($urandom), 1'($urandom), CHK_MODEL, '0, got);
               if (op == OP_LOAD || got) counted++;
            end
         end
      end
   endtask

   // Receiver, result check and watchdog
   always @(posedge clock) begin
      char_type want;
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_chars.size() == 0) begin
            fails++;
            $display("%0t: unexpected character, expected none, actual %h row_end %b frame_end %b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            want = pending_chars.pop_front();
            compare_field("char_code", {1'b0, want.glyph}, rsp_tdata);
            compare_field("row_end", {7'd0, want.row_end}, {7'd0, rsp_tuser});
            compare_field("frame_end", {7'd0, want.frame_end}, {7'd0, rsp_tlast});
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      bit got;
      fails         = 0;
      quiet_cycles  = 0;
      send_idle_pct = 22;
      recv_idle_pct = 85;
      text_width    = ROW_WIDTH_RESET;
      for (int i = 0; i < 11; i++) level_bound[i] = 0;
      clear_stats();

      // Directed: empty reads, single-pixel frame, extremes, a partly read mixed frame
      directed_rows[0]  = mk_row(OP_READ, 8'd0,   1'b0, CHK_NONE,  '0);
      directed_rows[1]  = mk_row(OP_LOAD, 8'd0,   1'b1, CHK_NONE,  '0);
      directed_rows[2]  = mk_row(OP_READ, 8'd0,   1'b0, CHK_GIVEN, {CH_BLOCK, 1'b1, 1'b1});
      directed_rows[3]  = mk_row(OP_READ, 8'd0,   1'b0, CHK_NONE,  '0);
      directed_rows[4]  = mk_row(OP_LOAD, 8'd0,   1'b0, CHK_NONE,  '0);
      directed_rows[5]  = mk_row(OP_LOAD, 8'd255, 1'b1, CHK_NONE,  '0);
      directed_rows[6]  = mk_row(OP_READ, 8'd0,   1'b0, CHK_GIVEN, {CH_SPACE, 1'b0, 1'b0});
      directed_rows[7]  = mk_row(OP_READ, 8'd0,   1'b0, CHK_GIVEN, {CH_BLOCK, 1'b1, 1'b1});
      directed_rows[8]  = mk_row(OP_LOAD, 8'd255, 1'b0, CHK_NONE,  '0);
      directed_rows[9]  = mk_row(OP_LOAD, 8'd255, 1'b1, CHK_NONE,  '0);
      directed_rows[10] = mk_row(OP_READ, 8'd0,   1'b0, CHK_GIVEN, {CH_BLOCK, 1'b0, 1'b0});
      directed_rows[11] = mk_row(OP_READ, 8'd0,   1'b0, CHK_GIVEN, {CH_BLOCK, 1'b1, 1'b1});
      directed_rows[12] = mk_row(OP_LOAD, 8'd40,  1'b0, CHK_MODEL, '0);
      directed_rows[13] = mk_row(OP_LOAD, 8'd100, 1'b0, CHK_MODEL, '0);
      directed_rows[14] = mk_row(OP_LOAD, 8'd160, 1'b0, CHK_MODEL, '0);
      directed_rows[15] = mk_row(OP_LOAD, 8'd220, 1'b0, CHK_MODEL, '0);
      directed_rows[16] = mk_row(OP_LOAD, 8'd130, 1'b0, CHK_MODEL, '0);
      directed_rows[17] = mk_row(OP_LOAD, 8'd0,   1'b0, CHK_MODEL, '0);
      directed_rows[18] = mk_row(OP_LOAD, 8'd255, 1'b0, CHK_MODEL, '0);
      directed_rows[19] = mk_row(OP_LOAD, 8'd75,  1'b1, CHK_MODEL, '0);
      directed_rows[20] = mk_row(OP_READ, 8'd0,   1'b0, CHK_MODEL, '0);
      directed_rows[21] = mk_row(OP_READ, 8'd0,   1'b0, CHK_MODEL, '0);
      directed_rows[22] = mk_row(OP_READ, 8'd0,   1'b0, CHK_MODEL, '0);
      directed_rows[23] = mk_row(OP_READ, 8'd0,   1'b0, CHK_MODEL, '0);
      directed_rows[24] = mk_row(OP_READ, 8'd0,   1'b0, CHK_MODEL, '0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         issue_request(directed_rows[i].op, directed_rows[i].pixel, directed_rows[i].mark,
                       directed_rows[i].kind, directed_rows[i].given, got);
      end

      // Sender mostly active, receiver mostly stalled
      write_row_width(8'd3);
      run_phase(PHASE_ITEMS);
      write_row_width(8'd0);
      run_phase(PHASE_ITEMS);

      // Sender mostly idle, receiver mostly ready
      send_idle_pct = 85;
      recv_idle_pct = 22;
      write_row_width(8'd255);
      run_phase(PHASE_ITEMS);
      write_row_width(8'd1);
      run_phase(PHASE_ITEMS);

      // Full rate on both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_row_width(8'd128);
      run_phase(PHASE_ITEMS);
      write_row_width(8'd200);
      run_phase(PHASE_ITEMS);

      await_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fails == 0 && pending_chars.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/agq_pkg.sv
rtl/agq_store.sv
rtl/agq_div.sv
rtl/agq_thresh.sv
rtl/adaptive_gray_to_ascii_quantizer.sv
test/testbench.sv
